// ===== hw/rtl/ccid_pkg.sv =====
// Shared types, constants and the restoring-divide step for the cell index decoder.
// No dependencies; used by ccid_div and calorimeter_cell_index_decoder_top.
package ccid_pkg;

  localparam int CELL_W     = 20;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int DIV_W      = 20;
  localparam int DVS_W      = 9;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = DIV_W / DIV_STEPS;
  localparam int MID_STG    = DIV_STAGES;
  localparam int OUT_STG    = 2 * DIV_STAGES + 1;
  localparam int PIPE_DEPTH = OUT_STG + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SUPER_MODULES = 3'd0,
    REG_CRYSTAL_Z     = 3'd1,
    REG_SAMPLING_Z    = 3'd2,
    REG_CRYSTAL_PHI   = 3'd3,
    REG_SAMPLING_PHI  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CH_SAMP_LO = 2'd0,
    CH_CRYSTAL = 2'd1,
    CH_SAMP_HI = 2'd2
  } chamber_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_a;
    logic [CELL_W-1:0] cell_b;
  } req_t;

  typedef struct packed {
    logic [11:0] row_index;
    logic [7:0]  col_index;
    chamber_t    chamber_code;
    logic [11:0] sector_index;
    logic        crystal_flag;
    logic        edge_flag;
    logic        neighbour_flag;
  } rsp_t;

  typedef struct packed {
    logic [DVS_W-1:0] rem;
    logic [DIV_W-1:0] quo;
    logic [DVS_W-1:0] dvs;
  } div_state_t;

  // DIV_STEPS restoring steps; quo shifts the dividend out and the quotient in
  function automatic div_state_t div_steps(input div_state_t s);
    div_state_t r;
    logic [DVS_W:0] t;
    r = s;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {r.rem, r.quo[DIV_W-1]};
      r.quo = {r.quo[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, r.dvs}) begin
        r.rem = DVS_W'(t - {1'b0, r.dvs});
        r.quo[0] = 1'b1;
      end else begin
        r.rem = t[DVS_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic chamber_t chamber_of(input logic [DVS_W-1:0] col,
                                          input logic [CFG_W-1:0] sz,
                                          input logic [DVS_W-1:0] band);
    chamber_t c;
    if (col < {2'b0, sz}) begin
      c = CH_SAMP_LO;
    end else if (col < band) begin
      c = CH_CRYSTAL;
    end else begin
      c = CH_SAMP_HI;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/ccid_div.sv =====
// Pipelined restoring divider, DIV_STEPS quotient bits per stage.
// Depends on ccid_pkg; stage enables come from the owner's pipeline control.
module ccid_div (
  input  logic                                clk,
  input  logic [ccid_pkg::DIV_STAGES-1:0]     en,
  input  logic [ccid_pkg::DIV_W-1:0]          dividend,
  input  logic [ccid_pkg::DVS_W-1:0]          divisor,
  output ccid_pkg::div_state_t                res
);

  ccid_pkg::div_state_t st [ccid_pkg::DIV_STAGES];
  ccid_pkg::div_state_t seed;

  assign seed = '{rem: '0, quo: dividend, dvs: divisor};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      st[0] <= ccid_pkg::div_steps(seed);
    end
    for (int k = 1; k < ccid_pkg::DIV_STAGES; k++) begin
      if (en[k]) begin
        st[k] <= ccid_pkg::div_steps(st[k-1]);
      end
    end
  end

  assign res = st[ccid_pkg::DIV_STAGES-1];

endmodule

// ===== hw/rtl/calorimeter_cell_index_decoder_top.sv =====
// Calorimeter cell index decoder: top level, pipeline control and config registers.
// Depends on ccid_pkg and ccid_div.
//
// Usage:
//   req channel (req_valid/req_ready/req_data) carries a pair of cell numbers.
//   rsp channel (rsp_valid/rsp_ready/rsp_data) returns row, column, chamber,
//   sector, crystal/edge flags of cell_a and the neighbour flag of the pair.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the five
//   geometry registers; cfg_ready is always high, unknown indexes are dropped.
//   Write config only with the pipeline empty.
// Timing:
//   12-stage pipeline: five divide stages for id / columns, one chamber stage,
//   five divide stages for row / phi, one output register. One request per
//   cycle is sustained while rsp_ready stays high.
// Reset:
//   rst clears all stage valid bits and loads super_modules 32, crystal_z 8,
//   sampling_z 16, crystal_phi 4, sampling_phi 4.
// Stall:
//   each stage holds while the stage ahead is full and blocked; empty stages
//   keep filling, so req_ready drops only once all 12 stages are occupied.
module calorimeter_cell_index_decoder_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  ccid_pkg::req_t                    req_data,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output ccid_pkg::rsp_t                    rsp_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ccid_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ccid_pkg::CFG_W-1:0]        cfg_data
);

  typedef struct packed {
    logic [ccid_pkg::DIV_W-1:0] row_a;
    logic [ccid_pkg::DIV_W-1:0] row_b;
    logic [ccid_pkg::DVS_W-1:0] col_a;
    ccid_pkg::chamber_t         chamber_a;
    ccid_pkg::chamber_t         chamber_b;
    logic                       edge_col;
    logic                       near_rc;
    logic [ccid_pkg::CFG_W-1:0] phi_a;
    logic [ccid_pkg::CFG_W-1:0] phi_b;
  } mid_t;

  typedef struct packed {
    logic [ccid_pkg::DIV_W-1:0] row_a;
    logic [ccid_pkg::DVS_W-1:0] col_a;
    ccid_pkg::chamber_t         chamber_a;
    ccid_pkg::chamber_t         chamber_b;
    logic                       edge_col;
    logic                       near_rc;
  } side_t;

  logic [ccid_pkg::CFG_W-1:0] super_modules;
  logic [ccid_pkg::CFG_W-1:0] crystal_z;
  logic [ccid_pkg::CFG_W-1:0] sampling_z;
  logic [ccid_pkg::CFG_W-1:0] crystal_phi;
  logic [ccid_pkg::CFG_W-1:0] sampling_phi;

  logic [ccid_pkg::PIPE_DEPTH-1:0] v;
  logic [ccid_pkg::PIPE_DEPTH-1:0] en;

  logic [ccid_pkg::CFG_W:0]   zsum;
  logic [ccid_pkg::DVS_W-1:0] cols;
  logic [ccid_pkg::DVS_W-1:0] band;
  logic                       zero_cols;

  ccid_pkg::div_state_t l1_a, l1_b, l2_a, l2_b;

  mid_t  mid, mid_next;
  side_t side [ccid_pkg::DIV_STAGES];
  side_t fin;
  ccid_pkg::rsp_t rsp_next;

  logic [ccid_pkg::DVS_W:0]   c10;
  logic [ccid_pkg::CFG_W-1:0] phi;
  logic                       phi_nz;
  logic                       ok0, ok1, edge_row, sec_eq;

  // ---------------- config registers ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      super_modules <= 7'd32;
      crystal_z     <= 7'd8;
      sampling_z    <= 7'd16;
      crystal_phi   <= 7'd4;
      sampling_phi  <= 7'd4;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ccid_pkg::REG_SUPER_MODULES: super_modules <= cfg_data;
        ccid_pkg::REG_CRYSTAL_Z:     crystal_z     <= cfg_data;
        ccid_pkg::REG_SAMPLING_Z:    sampling_z    <= cfg_data;
        ccid_pkg::REG_CRYSTAL_PHI:   crystal_phi   <= cfg_data;
        ccid_pkg::REG_SAMPLING_PHI:  sampling_phi  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign zsum      = {1'b0, sampling_z} + {1'b0, crystal_z};
  assign cols      = {zsum, 1'b0};
  assign band      = {2'b0, sampling_z} + {1'b0, crystal_z, 1'b0};
  assign zero_cols = (cols == '0);

  // ---------------- pipeline control ----------------
  always_comb begin
    en[ccid_pkg::OUT_STG] = !v[ccid_pkg::OUT_STG] || rsp_ready;
    for (int i = ccid_pkg::OUT_STG - 1; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign req_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= req_valid;
      end
      for (int i = 1; i < ccid_pkg::PIPE_DEPTH; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // ---------------- id / columns ----------------
  ccid_div u_div_row_a (
    .clk      (clk),
    .en       (en[ccid_pkg::DIV_STAGES-1:0]),
    .dividend (req_data.cell_a),
    .divisor  (cols),
    .res      (l1_a)
  );

  ccid_div u_div_row_b (
    .clk      (clk),
    .en       (en[ccid_pkg::DIV_STAGES-1:0]),
    .dividend (req_data.cell_b),
    .divisor  (cols),
    .res      (l1_b)
  );

  // ---------------- chamber stage ----------------
  always_comb begin
    mid_next.row_a = zero_cols ? '0 : l1_a.quo;
    mid_next.row_b = zero_cols ? '0 : l1_b.quo;
    mid_next.col_a = zero_cols ? '0 : l1_a.rem;
    mid_next.chamber_a = ccid_pkg::chamber_of(mid_next.col_a, sampling_z, band);
    mid_next.chamber_b = ccid_pkg::chamber_of(zero_cols ? '0 : l1_b.rem, sampling_z, band);
    mid_next.phi_a = (mid_next.chamber_a == ccid_pkg::CH_CRYSTAL) ? crystal_phi : sampling_phi;
    mid_next.phi_b = (mid_next.chamber_b == ccid_pkg::CH_CRYSTAL) ? crystal_phi : sampling_phi;
    c10 = {1'b0, mid_next.col_a};
    mid_next.edge_col = (c10 == '0) ||
                        (c10 == {3'b0, sampling_z}) ||
                        (c10 == {3'b0, sampling_z} - 10'd1) ||
                        (c10 == {1'b0, band}) ||
                        (c10 == {1'b0, band} - 10'd1) ||
                        (c10 == {1'b0, cols} - 10'd1);
    mid_next.near_rc =
      ((mid_next.row_a == mid_next.row_b) ||
       ({1'b0, mid_next.row_a} == {1'b0, mid_next.row_b} + 21'd1) ||
       ({1'b0, mid_next.row_b} == {1'b0, mid_next.row_a} + 21'd1)) &&
      ((l1_a.rem == l1_b.rem) || zero_cols ||
       ({1'b0, l1_a.rem} == {1'b0, l1_b.rem} + 10'd1) ||
       ({1'b0, l1_b.rem} == {1'b0, l1_a.rem} + 10'd1));
  end

  always_ff @(posedge clk) begin
    if (en[ccid_pkg::MID_STG]) begin
      mid <= mid_next;
    end
  end

  // ---------------- row / phi ----------------
  ccid_div u_div_sec_a (
    .clk      (clk),
    .en       (en[ccid_pkg::OUT_STG-1:ccid_pkg::MID_STG+1]),
    .dividend (mid.row_a),
    .divisor  ({2'b0, mid.phi_a}),
    .res      (l2_a)
  );

  ccid_div u_div_sec_b (
    .clk      (clk),
    .en       (en[ccid_pkg::OUT_STG-1:ccid_pkg::MID_STG+1]),
    .dividend (mid.row_b),
    .divisor  ({2'b0, mid.phi_b}),
    .res      (l2_b)
  );

  always_ff @(posedge clk) begin
    if (en[ccid_pkg::MID_STG+1]) begin
      side[0] <= '{row_a: mid.row_a, col_a: mid.col_a, chamber_a: mid.chamber_a,
                   chamber_b: mid.chamber_b, edge_col: mid.edge_col,
                   near_rc: mid.near_rc};
    end
    for (int k = 1; k < ccid_pkg::DIV_STAGES; k++) begin
      if (en[ccid_pkg::MID_STG+1+k]) begin
        side[k] <= side[k-1];
      end
    end
  end

  // ---------------- output stage ----------------
  assign fin = side[ccid_pkg::DIV_STAGES-1];

  always_comb begin
    phi    = l2_a.dvs[ccid_pkg::CFG_W-1:0];
    phi_nz = (phi != '0);
    ok0    = l2_a.quo <= {13'b0, super_modules};
    ok1    = ({1'b0, l2_a.quo} + 21'd1) <= {14'b0, super_modules};
    // row = m*phi or m*phi-1 with m in 0..super_modules
    edge_row = (fin.row_a == '0) ||
               (phi_nz && (((l2_a.rem == '0) && ok0) ||
                           ((l2_a.rem == {2'b0, phi} - 9'd1) && ok1)));
    // equal chambers imply equal phi, so a zero phi gives equal sectors
    sec_eq = !phi_nz || (l2_a.quo == l2_b.quo);
    rsp_next.row_index      = fin.row_a[11:0];
    rsp_next.col_index      = fin.col_a[7:0];
    rsp_next.chamber_code   = fin.chamber_a;
    rsp_next.sector_index   = phi_nz ? l2_a.quo[11:0] : 12'd0;
    rsp_next.crystal_flag   = (fin.chamber_a == ccid_pkg::CH_CRYSTAL);
    rsp_next.edge_flag      = fin.edge_col || edge_row;
    rsp_next.neighbour_flag = fin.near_rc && (fin.chamber_a == fin.chamber_b) && sec_eq;
  end

  always_ff @(posedge clk) begin
    if (en[ccid_pkg::OUT_STG]) begin
      rsp_data <= rsp_next;
    end
  end

  assign rsp_valid = v[ccid_pkg::OUT_STG];

  // ---------------- assertions ----------------
  a_l1_rem: assert property (@(posedge clk) disable iff (rst)
    v[ccid_pkg::DIV_STAGES-1] && !zero_cols |-> (l1_a.rem < cols) && (l1_b.rem < cols))
    else $error("column divider remainder out of range");

  a_l2_rem: assert property (@(posedge clk) disable iff (rst)
    v[ccid_pkg::OUT_STG-1] && (l2_a.dvs != '0) |-> (l2_a.rem < l2_a.dvs))
    else $error("sector divider remainder out of range");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> (&v))
    else $error("request blocked while a stage is empty");

  a_stall_keep: assert property (@(posedge clk) disable iff (rst)
    v[ccid_pkg::OUT_STG] && !rsp_ready && v[ccid_pkg::OUT_STG-1] |=> v[ccid_pkg::OUT_STG-1])
    else $error("item dropped behind stalled output");

endmodule

// ===== sim/tb_calorimeter_cell_index_decoder_top.sv =====
// Testbench for calorimeter_cell_index_decoder_top: a self-checking request/response bench.
// It predicts each decoded cell pair under several geometry settings and checks every field.
// Needs ccid_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_calorimeter_cell_index_decoder_top;

  localparam int CELL_W      = ccid_pkg::CELL_W;
  localparam int CFG_W       = ccid_pkg::CFG_W;
  localparam int CFG_IDX_W   = ccid_pkg::CFG_IDX_W;
  localparam int CELL_MAX    = (1 << CELL_W) - 1;
  localparam int IDX_MAX     = (1 << CFG_IDX_W) - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AT     = 100;
  localparam int HOLD_LEN    = 150;

  typedef struct {
    int                 row;
    int                 col;
    ccid_pkg::chamber_t chamber;
    int                 sector;
  } cell_pos_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  ccid_pkg::req_t       req_data = '0;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  ccid_pkg::rsp_t       rsp_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // geometry as the block should currently hold it
  logic [CFG_W-1:0] geo_sm = 7'd32;
  logic [CFG_W-1:0] geo_cz = 7'd8;
  logic [CFG_W-1:0] geo_sz = 7'd16;
  logic [CFG_W-1:0] geo_cphi = 7'd4;
  logic [CFG_W-1:0] geo_sphi = 7'd4;

  ccid_pkg::req_t cell_pairs_q[$];
  ccid_pkg::rsp_t decoded_q[$];
  int   pairs_queued = 0;
  int   pairs_taken = 0;
  int   err_cnt = 0;
  int   cycle_cnt = 0;
  int   send_gap_pct = 16;
  int   recv_stall_pct = 16;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  logic req_fire = 1'b0;

  calorimeter_cell_index_decoder_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int row_columns();
    return 2 * (int'(geo_sz) + int'(geo_cz));
  endfunction

  function automatic int rows_per_module(input ccid_pkg::chamber_t ch);
    return (ch == ccid_pkg::CH_CRYSTAL) ? int'(geo_cphi) : int'(geo_sphi);
  endfunction

  function automatic cell_pos_t locate_cell(input logic [CELL_W-1:0] cell_num);
    cell_pos_t p;
    int        cols;
    int        phi;
    cols = row_columns();
    if (cols == 0) begin
      p.row = 0;
      p.col = 0;
    end else begin
      p.row = int'(cell_num) / cols;
      p.col = int'(cell_num) % cols;
    end
    if (p.col < int'(geo_sz)) begin
      p.chamber = ccid_pkg::CH_SAMP_LO;
    end else if (p.col < int'(geo_sz) + 2 * int'(geo_cz)) begin
      p.chamber = ccid_pkg::CH_CRYSTAL;
    end else begin
      p.chamber = ccid_pkg::CH_SAMP_HI;
    end
    phi = rows_per_module(p.chamber);
    p.sector = (phi == 0) ? 0 : p.row / phi;
    return p;
  endfunction

  function automatic bit on_boundary(input cell_pos_t p);
    int sz;
    int band;
    int phi;
    int sm;
    sz = int'(geo_sz);
    band = sz + 2 * int'(geo_cz);
    phi = rows_per_module(p.chamber);
    sm = int'(geo_sm);
    if (p.col == 0 || p.col == sz || p.col == sz - 1 || p.col == band ||
        p.col == band - 1 || p.col == row_columns() - 1) begin
      return 1'b1;
    end
    if (p.row == 0) begin
      return 1'b1;
    end
    if (phi == 0) begin
      return 1'b0;
    end
    if (p.row % phi == 0 && p.row / phi <= sm) begin
      return 1'b1;
    end
    if ((p.row + 1) % phi == 0 && (p.row + 1) / phi >= 1 && (p.row + 1) / phi <= sm) begin
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic ccid_pkg::rsp_t decode_pair(input ccid_pkg::req_t r);
    ccid_pkg::rsp_t d;
    cell_pos_t      a;
    cell_pos_t      b;
    int             dr;
    int             dc;
    a = locate_cell(r.cell_a);
    b = locate_cell(r.cell_b);
    dr = a.row - b.row;
    dc = a.col - b.col;
    d.row_index = 12'(a.row);
    d.col_index = 8'(a.col);
    d.chamber_code = a.chamber;
    d.sector_index = 12'(a.sector);
    d.crystal_flag = (a.chamber == ccid_pkg::CH_CRYSTAL);
    d.edge_flag = on_boundary(a);
    d.neighbour_flag = (a.sector == b.sector) && (a.chamber == b.chamber) &&
                       dr >= -1 && dr <= 1 && dc >= -1 && dc <= 1;
    return d;
  endfunction

  function automatic logic [CELL_W-1:0] cell_at(input int row, input int col);
    return CELL_W'(row * row_columns() + col);
  endfunction

  // biased toward low rows where boundaries sit and toward touching pairs
  function automatic ccid_pkg::req_t random_pair();
    ccid_pkg::req_t r;
    int   cols;
    int   phi;
    int   span;
    int   a;
    int   b;
    int   dr;
    int   dc;
    int   pick;
    cols = row_columns();
    phi = (geo_cphi > geo_sphi) ? int'(geo_cphi) : int'(geo_sphi);
    if (phi == 0) begin
      phi = 1;
    end
    span = (int'(geo_sm) * phi + 2) * cols;
    if (cols == 0 || span > CELL_MAX || $urandom_range(99) < 40) begin
      a = $urandom_range(CELL_MAX);
    end else begin
      a = $urandom_range(span);
    end
    pick = $urandom_range(99);
    dr = int'($urandom_range(2)) - 1;
    dc = int'($urandom_range(2)) - 1;
    if (pick < 55) begin
      b = a + dr * cols + dc;
      if (b < 0 || b > CELL_MAX) begin
        b = a;
      end
    end else if (pick < 65) begin
      b = a;
    end else begin
      b = $urandom_range(CELL_MAX);
    end
    r.cell_a = CELL_W'(a);
    r.cell_b = CELL_W'(b);
    return r;
  endfunction

  task automatic push_pair(input logic [CELL_W-1:0] a, input logic [CELL_W-1:0] b);
    ccid_pkg::req_t r;
    r.cell_a = a;
    r.cell_b = b;
    cell_pairs_q.push_back(r);
    pairs_queued++;
  endtask

  task automatic wait_idle();
    while (pairs_taken != pairs_queued || decoded_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) begin
      cell_pairs_q.push_back(random_pair());
      pairs_queued++;
    end
    wait_idle();
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(input int sm, input int cz, input int sz,
                              input int cphi, input int sphi);
    write_reg(ccid_pkg::REG_SUPER_MODULES, CFG_W'(sm));
    write_reg(ccid_pkg::REG_CRYSTAL_Z, CFG_W'(cz));
    write_reg(ccid_pkg::REG_SAMPLING_Z, CFG_W'(sz));
    write_reg(ccid_pkg::REG_CRYSTAL_PHI, CFG_W'(cphi));
    write_reg(ccid_pkg::REG_SAMPLING_PHI, CFG_W'(sphi));
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      err_cnt++;
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_fire) begin
      if (cell_pairs_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        req_valid <= 1'b1;
        req_data <= cell_pairs_q.pop_front();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // response acceptor, with one long hold-off to back up the pipeline
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else if (!hold_done && pairs_taken >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    ccid_pkg::rsp_t exp_rsp;
    if (rst) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= req_valid && req_ready;
      if (cfg_valid && cfg_ready) begin
        case (ccid_pkg::cfg_reg_t'(cfg_index))
          ccid_pkg::REG_SUPER_MODULES: geo_sm = cfg_data;
          ccid_pkg::REG_CRYSTAL_Z:     geo_cz = cfg_data;
          ccid_pkg::REG_SAMPLING_Z:    geo_sz = cfg_data;
          ccid_pkg::REG_CRYSTAL_PHI:   geo_cphi = cfg_data;
          ccid_pkg::REG_SAMPLING_PHI:  geo_sphi = cfg_data;
          default: ;
        endcase
      end
      if (req_valid && req_ready) begin
        decoded_q.push_back(decode_pair(req_data));
        pairs_taken++;
      end
      if (rsp_valid && rsp_ready) begin
        if (decoded_q.size() == 0) begin
          $error("response with no request outstanding");
          err_cnt++;
        end else begin
          exp_rsp = decoded_q.pop_front();
          check_field("row_index", int'(exp_rsp.row_index), int'(rsp_data.row_index));
          check_field("col_index", int'(exp_rsp.col_index), int'(rsp_data.col_index));
          check_field("chamber_code", int'(exp_rsp.chamber_code), int'(rsp_data.chamber_code));
          check_field("sector_index", int'(exp_rsp.sector_index),
                      int'(rsp_data.sector_index));
          check_field("crystal_flag", int'(exp_rsp.crystal_flag),
                      int'(rsp_data.crystal_flag));
          check_field("edge_flag", int'(exp_rsp.edge_flag), int'(rsp_data.edge_flag));
          check_field("neighbour_flag", int'(exp_rsp.neighbour_flag),
                      int'(rsp_data.neighbour_flag));
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset geometry: 48 columns, band 16..31, 4 rows per module, 32 modules
    push_pair('0, '0);
    push_pair(CELL_W'(CELL_MAX), CELL_W'(CELL_MAX));
    push_pair('0, CELL_W'(CELL_MAX));
    push_pair(CELL_W'(CELL_MAX), '0);
    push_pair(20'hAAAAA, 20'h55555);
    push_pair(20'h55555, 20'hAAAAA);
    push_pair(cell_at(5, 1), cell_at(5, 1));
    push_pair(cell_at(5, 15), cell_at(5, 15));
    push_pair(cell_at(5, 16), cell_at(5, 16));
    push_pair(cell_at(5, 31), cell_at(5, 31));
    push_pair(cell_at(5, 32), cell_at(5, 32));
    push_pair(cell_at(5, 47), cell_at(5, 47));
    push_pair(cell_at(5, 20), cell_at(6, 21));
    push_pair(cell_at(5, 20), cell_at(4, 19));
    push_pair(cell_at(5, 20), cell_at(6, 22));
    push_pair(cell_at(7, 20), cell_at(8, 20));
    push_pair(cell_at(5, 15), cell_at(5, 16));
    push_pair(cell_at(127, 20), cell_at(127, 19));
    push_pair(cell_at(128, 20), cell_at(128, 21));
    push_pair(cell_at(131, 20), cell_at(130, 20));
    push_pair(cell_at(132, 20), cell_at(133, 21));
    wait_idle();
    push_random(400);

    // largest legal geometry, no idling on either side
    send_gap_pct = 0;
    recv_stall_pct = 0;
    set_geometry(64, 64, 64, 64, 64);
    push_random(200);
    send_gap_pct = 16;
    recv_stall_pct = 16;

    // smallest geometry: rows run far past 12 bits
    set_geometry(1, 1, 1, 1, 1);
    push_random(200);

    // zero columns
    set_geometry(5, 0, 0, 3, 2);
    push_pair('0, '0);
    push_pair(CELL_W'(CELL_MAX), '0);
    push_random(20);

    // zero rows per module in both chamber kinds
    set_geometry(10, 3, 5, 0, 0);
    push_random(100);

    // all register bits set: columns reach past 8 bits
    set_geometry(127, 127, 127, 127, 127);
    push_random(100);

    // writes to unused indexes must leave the geometry alone
    set_geometry(7, 2, 3, 2, 3);
    for (int i = int'(ccid_pkg::REG_SAMPLING_PHI) + 1; i <= IDX_MAX; i++) begin
      write_reg(CFG_IDX_W'(i), CFG_W'($urandom_range(127)));
    end
    push_random(100);

    for (int k = 0; k < 5; k++) begin
      set_geometry($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 64),
                   $urandom_range(1, 64), $urandom_range(1, 64));
      push_random(80);
    end

    repeat (30) @(negedge clk);
    if (err_cnt == 0 && decoded_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ccid_pkg.sv
hw/rtl/ccid_div.sv
hw/rtl/calorimeter_cell_index_decoder_top.sv
sim/tb_calorimeter_cell_index_decoder_top.sv
